// File: hw/rtl/vpa_pkg.sv
// shared types and constants of the variable partition allocator
package vpa_pkg;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PSCAN,
    S_PCHK,
    S_FSCAN,
    S_FCHK,
    S_CLR,
    S_PACK,
    S_GRANT,
    S_MSCAN,
    S_MCHK,
    S_REL
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_PSCAN,
    OP_FSCAN,
    OP_CLR,
    OP_PACK,
    OP_GRANT,
    OP_MSCAN,
    OP_RELEASE,
    OP_FAIL
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_UNKNOWN_ID = 3'd2,
    ST_ZERO_SIZE  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  // fit policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // request actions
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MEM_SIZE = 2'd0;
  localparam logic [1:0] CFG_POLICY   = 2'd1;
  localparam logic [1:0] CFG_MIN_FRAG = 2'd2;

  // reset values
  localparam logic [15:0] RST_MEM_SIZE = 16'd1024;
  localparam logic [15:0] RST_MIN_FRAG = 16'd10;

  // controller to datapath
  typedef struct packed {
    op_t     op;
    status_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_rel;
    logic zero_size;
    logic p_last;
    logic slot_ok;
    logic f_last;
    logic best_ok;
    logic total_short;
    logic compacted;
    logic pack_last;
    logic merge_ok;
  } stat_t;

endpackage

// File: hw/rtl/vpa_ctrl.sv
// controller state machine of the allocator
module vpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  vpa_pkg::stat_t stat,
  output vpa_pkg::cmd_t  cmd
);

  vpa_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != vpa_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = vpa_pkg::OP_NONE;
    cmd.code  = vpa_pkg::ST_OK;
    unique case (state_r)
      vpa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op    = vpa_pkg::OP_ACCEPT;
          state_nxt = vpa_pkg::S_PSCAN;
        end
      end
      vpa_pkg::S_PSCAN: begin
        cmd.op = vpa_pkg::OP_PSCAN;
        if (stat.p_last) state_nxt = vpa_pkg::S_PCHK;
      end
      vpa_pkg::S_PCHK: begin
        if (stat.is_rel) begin
          if (stat.slot_ok) begin
            state_nxt = vpa_pkg::S_MSCAN;
          end else begin
            cmd.op    = vpa_pkg::OP_FAIL;
            cmd.code  = vpa_pkg::ST_UNKNOWN_ID;
            state_nxt = vpa_pkg::S_IDLE;
          end
        end else if (stat.zero_size) begin
          cmd.op    = vpa_pkg::OP_FAIL;
          cmd.code  = vpa_pkg::ST_ZERO_SIZE;
          state_nxt = vpa_pkg::S_IDLE;
        end else if (!stat.slot_ok) begin
          cmd.op    = vpa_pkg::OP_FAIL;
          cmd.code  = vpa_pkg::ST_TABLE_FULL;
          state_nxt = vpa_pkg::S_IDLE;
        end else begin
          state_nxt = vpa_pkg::S_FSCAN;
        end
      end
      vpa_pkg::S_FSCAN: begin
        cmd.op = vpa_pkg::OP_FSCAN;
        if (stat.f_last) state_nxt = vpa_pkg::S_FCHK;
      end
      vpa_pkg::S_FCHK: begin
        if (stat.best_ok) begin
          state_nxt = vpa_pkg::S_GRANT;
        end else if (stat.total_short || stat.compacted) begin
          cmd.op    = vpa_pkg::OP_FAIL;
          cmd.code  = vpa_pkg::ST_NO_SPACE;
          state_nxt = vpa_pkg::S_IDLE;
        end else begin
          state_nxt = vpa_pkg::S_CLR;
        end
      end
      vpa_pkg::S_CLR: begin
        cmd.op    = vpa_pkg::OP_CLR;
        state_nxt = vpa_pkg::S_PACK;
      end
      vpa_pkg::S_PACK: begin
        cmd.op = vpa_pkg::OP_PACK;
        if (stat.pack_last) state_nxt = vpa_pkg::S_FSCAN;
      end
      vpa_pkg::S_GRANT: begin
        cmd.op    = vpa_pkg::OP_GRANT;
        state_nxt = vpa_pkg::S_IDLE;
      end
      vpa_pkg::S_MSCAN: begin
        cmd.op = vpa_pkg::OP_MSCAN;
        if (stat.f_last) state_nxt = vpa_pkg::S_MCHK;
      end
      vpa_pkg::S_MCHK: begin
        if (stat.merge_ok) begin
          state_nxt = vpa_pkg::S_REL;
        end else begin
          cmd.op    = vpa_pkg::OP_FAIL;
          cmd.code  = vpa_pkg::ST_TABLE_FULL;
          state_nxt = vpa_pkg::S_IDLE;
        end
      end
      vpa_pkg::S_REL: begin
        cmd.op    = vpa_pkg::OP_RELEASE;
        state_nxt = vpa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = vpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/vpa_datapath.sv
// block tables, scan registers and result register of the allocator
module vpa_datapath #(
  parameter int FE = 32,
  parameter int PE = 16,
  parameter int A  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vpa_pkg::cmd_t  cmd,
  output vpa_pkg::stat_t stat,
  input  logic           in_action,
  input  logic [15:0]    in_request_size,
  input  logic [15:0]    in_proc_id,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  output logic [2:0]     out_status,
  output logic [15:0]    out_granted_id,
  output logic [15:0]    out_block_start,
  output logic [15:0]    out_block_size
);

  localparam int FW = $clog2(FE);
  localparam int PW = (PE > 1) ? $clog2(PE) : 1;
  localparam int RW = PW + 1;
  localparam int TW = A + FW + 1;
  localparam logic [FW:0] F_LAST = (FW + 1)'(FE - 1);
  localparam logic [PW:0] P_LAST = (PW + 1)'(PE - 1);

  // configuration
  logic [1:0]  policy_r;
  logic [15:0] min_frag_r;

  // free table
  logic [A-1:0] fr_start_r [FE];
  logic [A-1:0] fr_len_r   [FE];
  logic         fr_used_r  [FE];

  // process table
  logic [A-1:0]  pr_start_r [PE];
  logic [A-1:0]  pr_len_r   [PE];
  logic [15:0]   pr_id_r    [PE];
  logic [RW-1:0] pr_rank_r  [PE];
  logic          pr_used_r  [PE];
  logic [15:0]   next_id_r;

  // request and scan state
  logic          act_r;
  logic [15:0]   size_r;
  logic [15:0]   id_r;
  logic [FW:0]   fi_r;
  logic [PW:0]   pi_r;
  logic [PW:0]   rk_r;
  logic [PW-1:0] slot_r;
  logic          slot_ok_r;
  logic [FW-1:0] best_r;
  logic          best_ok_r;
  logic [TW-1:0] total_r;
  logic          cmp_r;
  logic [A-1:0]  pack_addr_r;
  logic [FW-1:0] lo_r, hi_r, emp_r;
  logic          lo_ok_r, hi_ok_r, emp_ok_r;

  // result register
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_id_r, out_start_r, out_size_r;

  // current entries
  logic [FW-1:0] fidx;
  logic [PW-1:0] pidx;
  logic [A-1:0]  cur_st, cur_len, b_st, b_len;
  logic [31:0]   cur_len32, size32, left32, min32, cfg32;
  logic          fits, better, whole;
  logic [A-1:0]  ps, pl, plen, lo_sum;
  logic [A:0]    ps_end;
  logic [31:0]   ps32, pl32, plen32, bst32;
  logic [15:0]   id_inc;

  assign fidx      = fi_r[FW-1:0];
  assign pidx      = pi_r[PW-1:0];
  assign cur_st    = fr_start_r[fidx];
  assign cur_len   = fr_len_r[fidx];
  assign b_st      = fr_start_r[best_r];
  assign b_len     = fr_len_r[best_r];
  assign cur_len32 = 32'(cur_len);
  assign size32    = 32'(size_r);
  assign min32     = 32'(min_frag_r);
  assign cfg32     = 32'(cfg_data);
  assign fits      = fr_used_r[fidx] && (cur_len32 >= size32);
  assign left32    = 32'(b_len) - size32;
  assign whole     = (left32 == 32'd0) || (left32 < min32);
  assign plen      = whole ? b_len : size32[A-1:0];
  assign plen32    = 32'(plen);
  assign bst32     = 32'(b_st);
  assign ps        = pr_start_r[slot_r];
  assign pl        = pr_len_r[slot_r];
  assign ps32      = 32'(ps);
  assign pl32      = 32'(pl);
  assign ps_end    = (A + 1)'(ps) + (A + 1)'(pl);
  assign lo_sum    = fr_len_r[lo_r] + pl + (hi_ok_r ? fr_len_r[hi_r] : '0);
  assign id_inc    = next_id_r + 16'd1;

  // policy order between the current entry and the best so far
  always_comb begin
    if (policy_r == vpa_pkg::FIT_BEST) begin
      better = (cur_len < b_len) || ((cur_len == b_len) && (cur_st < b_st));
    end else if (policy_r == vpa_pkg::FIT_WORST) begin
      better = (cur_len > b_len) || ((cur_len == b_len) && (cur_st < b_st));
    end else begin
      better = cur_st < b_st;
    end
  end

  // controller status
  assign stat.is_rel      = (act_r == vpa_pkg::ACT_RELEASE);
  assign stat.zero_size   = (size_r == 16'd0);
  assign stat.p_last      = (pi_r == P_LAST);
  assign stat.slot_ok     = slot_ok_r;
  assign stat.f_last      = (fi_r == F_LAST);
  assign stat.best_ok     = best_ok_r;
  assign stat.total_short = (48'(total_r) < 48'(size_r));
  assign stat.compacted   = cmp_r;
  assign stat.pack_last   = (rk_r == P_LAST) && (pi_r == P_LAST);
  assign stat.merge_ok    = lo_ok_r || hi_ok_r || emp_ok_r;

  // control state, configuration, free table and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= vpa_pkg::FIT_FIRST;
      min_frag_r  <= vpa_pkg::RST_MIN_FRAG;
      for (int i = 0; i < FE; i++) begin
        fr_used_r[i]  <= 1'b0;
        fr_start_r[i] <= '0;
        fr_len_r[i]   <= '0;
      end
      fr_used_r[0] <= 1'b1;
      fr_len_r[0]  <= A'(32'(vpa_pkg::RST_MEM_SIZE));
      for (int i = 0; i < PE; i++) pr_used_r[i] <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
      fi_r        <= '0;
      pi_r        <= '0;
      rk_r        <= '0;
      slot_ok_r   <= 1'b0;
      best_ok_r   <= 1'b0;
      cmp_r       <= 1'b0;
      lo_ok_r     <= 1'b0;
      hi_ok_r     <= 1'b0;
      emp_ok_r    <= 1'b0;
      total_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      // configuration write
      if (cfg_valid) begin
        unique case (cfg_index)
          vpa_pkg::CFG_MEM_SIZE: begin
            for (int i = 0; i < FE; i++) fr_used_r[i] <= 1'b0;
            for (int i = 0; i < PE; i++) pr_used_r[i] <= 1'b0;
            fr_used_r[0]  <= (cfg_data != 16'd0);
            fr_start_r[0] <= '0;
            fr_len_r[0]   <= cfg32[A-1:0];
          end
          vpa_pkg::CFG_POLICY:   policy_r   <= cfg_data[1:0];
          vpa_pkg::CFG_MIN_FRAG: min_frag_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (cmd.op)
        vpa_pkg::OP_ACCEPT: begin
          fi_r      <= '0;
          pi_r      <= '0;
          rk_r      <= '0;
          slot_ok_r <= 1'b0;
          best_ok_r <= 1'b0;
          cmp_r     <= 1'b0;
          lo_ok_r   <= 1'b0;
          hi_ok_r   <= 1'b0;
          emp_ok_r  <= 1'b0;
          total_r   <= '0;
        end
        // process table scan: free slot or newest matching id
        vpa_pkg::OP_PSCAN: begin
          if (act_r == vpa_pkg::ACT_ALLOC) begin
            if (!pr_used_r[pidx] && !slot_ok_r) begin
              slot_r    <= pidx;
              slot_ok_r <= 1'b1;
            end
          end else if (pr_used_r[pidx] && (pr_id_r[pidx] == id_r) &&
                       (!slot_ok_r || (pr_rank_r[pidx] < pr_rank_r[slot_r]))) begin
            slot_r    <= pidx;
            slot_ok_r <= 1'b1;
          end
          pi_r <= stat.p_last ? '0 : pi_r + 1'b1;
        end
        // free table scan: pick block and sum free space
        vpa_pkg::OP_FSCAN: begin
          if (fits && (!best_ok_r || better)) begin
            best_r    <= fidx;
            best_ok_r <= 1'b1;
          end
          if (fr_used_r[fidx]) total_r <= total_r + TW'(cur_len);
          fi_r <= stat.f_last ? '0 : fi_r + 1'b1;
        end
        // compaction: all free space becomes one block at address zero
        vpa_pkg::OP_CLR: begin
          for (int i = 0; i < FE; i++) fr_used_r[i] <= 1'b0;
          fr_used_r[0]  <= 1'b1;
          fr_start_r[0] <= '0;
          fr_len_r[0]   <= total_r[A-1:0];
          pack_addr_r   <= total_r[A-1:0];
          total_r       <= '0;
          fi_r          <= '0;
          pi_r          <= '0;
          rk_r          <= '0;
          best_ok_r     <= 1'b0;
          cmp_r         <= 1'b1;
        end
        // packing walks ranks newest first, entries within each rank
        vpa_pkg::OP_PACK: begin
          if (pr_used_r[pidx] && (pr_rank_r[pidx] == rk_r)) begin
            pack_addr_r <= pack_addr_r + pr_len_r[pidx];
          end
          if (stat.p_last) begin
            pi_r <= '0;
            rk_r <= rk_r + 1'b1;
          end else begin
            pi_r <= pi_r + 1'b1;
          end
        end
        vpa_pkg::OP_GRANT: begin
          if (whole) begin
            fr_used_r[best_r] <= 1'b0;
          end else begin
            fr_start_r[best_r] <= b_st + size32[A-1:0];
            fr_len_r[best_r]   <= left32[A-1:0];
          end
          pr_used_r[slot_r] <= 1'b1;
          next_id_r         <= id_inc;
          out_valid_r       <= 1'b1;
          out_status_r      <= vpa_pkg::ST_OK;
          out_id_r          <= id_inc;
          out_start_r       <= bst32[15:0];
          out_size_r        <= plen32[15:0];
        end
        // neighbor search for merge and first empty entry
        vpa_pkg::OP_MSCAN: begin
          if (fr_used_r[fidx]) begin
            if ((A + 1)'(cur_st) + (A + 1)'(cur_len) == (A + 1)'(ps)) begin
              lo_r    <= fidx;
              lo_ok_r <= 1'b1;
            end else if ((A + 1)'(cur_st) == ps_end) begin
              hi_r    <= fidx;
              hi_ok_r <= 1'b1;
            end
          end else if (!emp_ok_r) begin
            emp_r    <= fidx;
            emp_ok_r <= 1'b1;
          end
          fi_r <= stat.f_last ? '0 : fi_r + 1'b1;
        end
        vpa_pkg::OP_RELEASE: begin
          if (lo_ok_r) begin
            fr_len_r[lo_r] <= lo_sum;
            if (hi_ok_r) fr_used_r[hi_r] <= 1'b0;
          end else if (hi_ok_r) begin
            fr_start_r[hi_r] <= ps;
            fr_len_r[hi_r]   <= fr_len_r[hi_r] + pl;
          end else begin
            fr_used_r[emp_r]  <= 1'b1;
            fr_start_r[emp_r] <= ps;
            fr_len_r[emp_r]   <= pl;
          end
          pr_used_r[slot_r] <= 1'b0;
          out_valid_r       <= 1'b1;
          out_status_r      <= vpa_pkg::ST_OK;
          out_id_r          <= id_r;
          out_start_r       <= ps32[15:0];
          out_size_r        <= pl32[15:0];
        end
        vpa_pkg::OP_FAIL: begin
          out_valid_r  <= 1'b1;
          out_status_r <= cmd.code;
          out_id_r     <= (act_r == vpa_pkg::ACT_RELEASE) ? id_r : 16'd0;
          out_start_r  <= 16'd0;
          out_size_r   <= 16'd0;
        end
        default: ;
      endcase
    end
  end

  // request latch and process table payload
  always_ff @(posedge clk) begin
    if (cmd.op == vpa_pkg::OP_ACCEPT) begin
      act_r  <= in_action;
      size_r <= in_request_size;
      id_r   <= in_proc_id;
    end
    if ((cmd.op == vpa_pkg::OP_PACK) && pr_used_r[pidx] && (pr_rank_r[pidx] == rk_r)) begin
      pr_start_r[pidx] <= pack_addr_r;
    end
    if (cmd.op == vpa_pkg::OP_GRANT) begin
      for (int i = 0; i < PE; i++) begin
        if (pr_used_r[i]) pr_rank_r[i] <= pr_rank_r[i] + 1'b1;
      end
      pr_start_r[slot_r] <= b_st;
      pr_len_r[slot_r]   <= plen;
      pr_id_r[slot_r]    <= id_inc;
      pr_rank_r[slot_r]  <= '0;
    end
    if (cmd.op == vpa_pkg::OP_RELEASE) begin
      for (int i = 0; i < PE; i++) begin
        if (pr_used_r[i] && (pr_rank_r[i] > pr_rank_r[slot_r])) begin
          pr_rank_r[i] <= pr_rank_r[i] - 1'b1;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_granted_id  = out_id_r;
  assign out_block_start = out_start_r;
  assign out_block_size  = out_size_r;

endmodule

// File: hw/rtl/variable_partition_allocator_unit.sv
// top level of the variable partition allocator
//
// Keeps a free block table and a process block table for one memory.
// A request transfers on start while busy is low: in_action 0 allocates
// in_request_size units under a new id, in_action 1 releases in_proc_id.
// Exactly one result follows each request: out_valid is high for one
// cycle with out_status, out_granted_id, out_block_start, out_block_size.
// The receiver cannot stall; the result is taken in that cycle.
// Requests are served by sequential table scans, one entry per cycle:
//   process table scan, then free table scan, then an update; zero size,
//   unknown id or full process table end after the process table scan.
//   An allocate that needs compaction then merges all free space into one
//   block, packs the process blocks and scans the free table again; packing
//   walks the process table once for each age rank.
// A new request may be started in the cycle the result is shown.
// Configuration writes transfer on cfg_valid (cfg_ready is always high).
// The user must make them only while busy is low; the unit does not check it.
// Writing memory_size rebuilds the free table, drops all process blocks.
// Synchronous reset restores memory size 1024, first fit, fragment 10.
module variable_partition_allocator_unit #(
  parameter int FREE_ENTRIES = 32,
  parameter int PROC_ENTRIES = 16,
  parameter int ADDR_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_proc_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_id,
  output logic [15:0] out_block_start,
  output logic [15:0] out_block_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vpa_pkg::cmd_t  cmd;
  vpa_pkg::stat_t stat;
  logic           busy_w;

  assign cfg_ready = 1'b1;
  assign busy      = busy_w;

  // controller
  vpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy_w),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  vpa_datapath #(
    .FE (FREE_ENTRIES),
    .PE (PROC_ENTRIES),
    .A  (ADDR_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_request_size (in_request_size),
    .in_proc_id      (in_proc_id),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_granted_id  (out_granted_id),
    .out_block_start (out_block_start),
    .out_block_size  (out_block_size)
  );

  // every finished request shows its result as busy drops
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("request finished without result");

  // a result is never shown while a request is in progress
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result during busy");

  // one result per request
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("repeated result");

  // an accepted request starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request not started");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the variable partition allocator unit
module testbench;

  localparam int FREE_N = 32;
  localparam int PROC_N = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic        action;
    logic [15:0] req_size;
    logic [15:0] pid;
    bit          id_back;  // pid is an offset below the last id given
  } request_t;

  typedef struct {
    vpa_pkg::status_t status;
    logic [15:0]      id;
    logic [15:0]      bstart;
    logic [15:0]      bsize;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [15:0] in_request_size;
  logic [15:0] in_proc_id;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_granted_id;
  logic [15:0] out_block_start;
  logic [15:0] out_block_size;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       mismatches;
  int       gap_left;
  bit       gaps_on;
  int       stall_cycles;

  // shadow copy of the allocator tables
  logic [15:0] mem_size_q;
  logic [1:0]  policy_q;
  logic [15:0] min_frag_q;
  logic [15:0] fr_start[FREE_N];
  logic [15:0] fr_len[FREE_N];
  bit          fr_used[FREE_N];
  logic [15:0] pr_start[PROC_N];
  logic [15:0] pr_len[PROC_N];
  logic [15:0] pr_id[PROC_N];
  int          pr_age[PROC_N];
  bit          pr_used[PROC_N];
  logic [15:0] next_id;

  variable_partition_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_request_size(in_request_size), .in_proc_id(in_proc_id),
    .out_valid(out_valid), .out_status(out_status), .out_granted_id(out_granted_id),
    .out_block_start(out_block_start), .out_block_size(out_block_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // rebuild both tables from the memory size
  function automatic void clear_tables();
    for (int i = 0; i < FREE_N; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_used[i] = 1'b0;
    end
    for (int i = 0; i < PROC_N; i++) begin
      pr_start[i] = '0; pr_len[i] = '0; pr_id[i] = '0; pr_age[i] = 0; pr_used[i] = 1'b0;
    end
    if (mem_size_q != 0) begin
      fr_len[0] = mem_size_q;
      fr_used[0] = 1'b1;
    end
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      vpa_pkg::CFG_MEM_SIZE: begin
        mem_size_q = data;
        clear_tables();
      end
      vpa_pkg::CFG_POLICY: policy_q = data[1:0];
      vpa_pkg::CFG_MIN_FRAG: min_frag_q = data;
      default: ;
    endcase
  endfunction

  // free block chosen by the fit policy, -1 if none is large enough
  function automatic int choose_block(int sz);
    int  pick;
    bit  better;
    pick = -1;
    for (int i = 0; i < FREE_N; i++) begin
      if (fr_used[i] && int'(fr_len[i]) >= sz) begin
        if (pick < 0) pick = i;
        else begin
          if (policy_q == vpa_pkg::FIT_BEST)
            better = fr_len[i] < fr_len[pick] ||
                     (fr_len[i] == fr_len[pick] && fr_start[i] < fr_start[pick]);
          else if (policy_q == vpa_pkg::FIT_WORST)
            better = fr_len[i] > fr_len[pick] ||
                     (fr_len[i] == fr_len[pick] && fr_start[i] < fr_start[pick]);
          else
            better = fr_start[i] < fr_start[pick];
          if (better) pick = i;
        end
      end
    end
    return pick;
  endfunction

  // all free space to one block at 0, processes packed newest first
  function automatic void compact_memory(longint total);
    longint addr;
    addr = total;
    for (int i = 0; i < FREE_N; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_used[i] = 1'b0;
    end
    fr_len[0] = total[15:0];
    fr_used[0] = 1'b1;
    for (int r = 0; r < PROC_N; r++)
      for (int i = 0; i < PROC_N; i++)
        if (pr_used[i] && pr_age[i] == r) begin
          pr_start[i] = addr[15:0];
          addr += pr_len[i];
        end
  endfunction

  function automatic answer_t allocate_block(logic [15:0] sz);
    answer_t a;
    int      slot;
    int      idx;
    longint  total;
    int      left;
    logic [15:0] grant;
    a = '{vpa_pkg::ST_OK, 16'd0, 16'd0, 16'd0};
    slot = -1;
    if (sz == 0) begin
      a.status = vpa_pkg::ST_ZERO_SIZE;
      return a;
    end
    for (int i = PROC_N - 1; i >= 0; i--)
      if (!pr_used[i]) slot = i;
    if (slot < 0) begin
      a.status = vpa_pkg::ST_TABLE_FULL;
      return a;
    end
    idx = choose_block(sz);
    if (idx < 0) begin
      total = 0;
      for (int i = 0; i < FREE_N; i++)
        if (fr_used[i]) total += fr_len[i];
      if (total < sz) begin
        a.status = vpa_pkg::ST_NO_SPACE;
        return a;
      end
      compact_memory(total);
      idx = choose_block(sz);
      if (idx < 0) begin
        a.status = vpa_pkg::ST_NO_SPACE;
        return a;
      end
    end
    pr_start[slot] = fr_start[idx];
    left = int'(fr_len[idx]) - int'(sz);
    if (left == 0 || left < int'(min_frag_q)) begin
      grant = fr_len[idx];
      fr_used[idx] = 1'b0; fr_start[idx] = '0; fr_len[idx] = '0;
    end else begin
      grant = sz;
      fr_start[idx] = fr_start[idx] + sz;
      fr_len[idx] = left[15:0];
    end
    for (int i = 0; i < PROC_N; i++)
      if (pr_used[i]) pr_age[i]++;
    next_id = next_id + 16'd1;
    pr_used[slot] = 1'b1;
    pr_age[slot] = 0;
    pr_len[slot] = grant;
    pr_id[slot] = next_id;
    a.id = next_id;
    a.bstart = pr_start[slot];
    a.bsize = grant;
    return a;
  endfunction

  function automatic answer_t release_block(logic [15:0] id);
    answer_t a;
    int      j, lo, hi, e;
    longint  ps, pl, n;
    a = '{vpa_pkg::ST_OK, id, 16'd0, 16'd0};
    j = -1; lo = -1; hi = -1; e = -1;
    for (int i = 0; i < PROC_N; i++)
      if (pr_used[i] && pr_id[i] == id && (j < 0 || pr_age[i] < pr_age[j])) j = i;
    if (j < 0) begin
      a.status = vpa_pkg::ST_UNKNOWN_ID;
      return a;
    end
    ps = pr_start[j];
    pl = pr_len[j];
    for (int i = 0; i < FREE_N; i++) begin
      if (fr_used[i]) begin
        if (longint'(fr_start[i]) + longint'(fr_len[i]) == ps) lo = i;
        else if (longint'(fr_start[i]) == ps + pl) hi = i;
      end
    end
    if (lo >= 0) begin
      n = longint'(fr_len[lo]) + pl;
      if (hi >= 0) begin
        n += fr_len[hi];
        fr_used[hi] = 1'b0; fr_start[hi] = '0; fr_len[hi] = '0;
      end
      fr_len[lo] = n[15:0];
    end else if (hi >= 0) begin
      n = longint'(fr_len[hi]) + pl;
      fr_start[hi] = ps[15:0];
      fr_len[hi] = n[15:0];
    end else begin
      for (int i = FREE_N - 1; i >= 0; i--)
        if (!fr_used[i]) e = i;
      if (e < 0) begin
        a.status = vpa_pkg::ST_TABLE_FULL;
        return a;
      end
      fr_used[e] = 1'b1;
      fr_start[e] = ps[15:0];
      fr_len[e] = pl[15:0];
    end
    for (int i = 0; i < PROC_N; i++)
      if (pr_used[i] && pr_age[i] > pr_age[j]) pr_age[i]--;
    pr_used[j] = 1'b0;
    a.bstart = ps[15:0];
    a.bsize = pl[15:0];
    return a;
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      start <= 1'b1;
      in_action <= pending_reqs[0].action;
      in_request_size <= pending_reqs[0].req_size;
      in_proc_id <= pending_reqs[0].id_back ? next_id - pending_reqs[0].pid
                                            : pending_reqs[0].pid;
    end else begin
      start <= 1'b0;
    end
  end

  // request transfer: predict the answer
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      void'(pending_reqs.pop_front());
      if (in_action == vpa_pkg::ACT_ALLOC)
        expected_answers.push_back(allocate_block(in_request_size));
      else expected_answers.push_back(release_block(in_proc_id));
      if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
    end
    if (rst_n && cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
  end

  // result monitor
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status %0d", out_status);
      end else begin
        want = expected_answers.pop_front();
        if (out_status !== want.status || out_granted_id !== want.id ||
            out_block_start !== want.bstart || out_block_size !== want.bsize) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d id=%0d start=%0d size=%0d,",
                      " got st=%0d id=%0d start=%0d size=%0d"},
                     want.status, want.id, want.bstart, want.bsize,
                     out_status, out_granted_id, out_block_start, out_block_size);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_req(logic act, logic [15:0] sz, logic [15:0] pid, bit back);
    request_t r;
    r.action = act;
    r.req_size = sz;
    r.pid = pid;
    r.id_back = back;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() > 0 || expected_answers.size() > 0 || busy || start)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic for one register setting
  task automatic random_phase(int count);
    int r;
    int msz;
    msz = mem_size_q;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        r = $urandom_range(0, 99);
        if (r < 4) queue_req(vpa_pkg::ACT_ALLOC, 16'd0, 16'($urandom), 1'b0);
        else if (r < 10)
          queue_req(vpa_pkg::ACT_ALLOC, 16'($urandom), 16'($urandom), 1'b0);
        else if (r < 22)
          queue_req(vpa_pkg::ACT_ALLOC, 16'($urandom_range(1, msz > 0 ? msz : 1)),
                    16'($urandom), 1'b0);
        else
          queue_req(vpa_pkg::ACT_ALLOC, 16'($urandom_range(1, msz / 6 + 1)),
                    16'($urandom), 1'b0);
      end else if (r < 94) begin
        queue_req(vpa_pkg::ACT_RELEASE, 16'($urandom), 16'($urandom_range(0, 20)), 1'b1);
      end else begin
        queue_req(vpa_pkg::ACT_RELEASE, 16'($urandom), 16'($urandom), 1'b0);
      end
    end
    wait_drained();
  endtask

  task automatic set_regs(logic [15:0] msz, logic [1:0] pol, logic [15:0] frag);
    write_reg(vpa_pkg::CFG_POLICY, {14'd0, pol});
    write_reg(vpa_pkg::CFG_MIN_FRAG, frag);
    write_reg(vpa_pkg::CFG_MEM_SIZE, msz);
  endtask

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = 1'b0;
    in_request_size = '0;
    in_proc_id = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    gap_left = 0;
    gaps_on = 1'b1;
    stall_cycles = 0;
    mem_size_q = vpa_pkg::RST_MEM_SIZE;
    policy_q = vpa_pkg::FIT_FIRST;
    min_frag_q = vpa_pkg::RST_MIN_FRAG;
    next_id = '0;
    clear_tables();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, zero size, oversize, unknown ids, compaction
    queue_req(vpa_pkg::ACT_ALLOC, 16'd0, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(vpa_pkg::ACT_RELEASE, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(vpa_pkg::ACT_RELEASE, 16'd0, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'd100, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'd100, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'd100, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_RELEASE, 16'd0, 16'd2, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'd800, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_ALLOC, 16'd20, 16'd0, 1'b0);
    // allocate into a full memory, then release one id twice
    for (int k = 0; k < 13; k++) queue_req(vpa_pkg::ACT_ALLOC, 16'd1, 16'd0, 1'b0);
    queue_req(vpa_pkg::ACT_RELEASE, 16'd0, 16'd1, 1'b0);
    queue_req(vpa_pkg::ACT_RELEASE, 16'd0, 16'd1, 1'b0);
    wait_drained();

    // random phases over several register settings, extremes included
    set_regs(16'd1024, vpa_pkg::FIT_FIRST, 16'd10);
    random_phase(200);
    set_regs(16'd256, vpa_pkg::FIT_BEST, 16'd0);
    random_phase(200);
    set_regs(16'hFFFF, vpa_pkg::FIT_WORST, 16'hFFFF);
    random_phase(180);
    set_regs(16'd1, 2'd3, 16'd0);
    random_phase(60);
    set_regs(16'd0, vpa_pkg::FIT_BEST, 16'd5);
    random_phase(40);
    set_regs(16'd4096, vpa_pkg::FIT_BEST, 16'd4);
    random_phase(200);
    set_regs(16'd200, vpa_pkg::FIT_WORST, 16'd20);
    random_phase(150);
    gaps_on = 1'b0;
    set_regs(16'd600, vpa_pkg::FIT_FIRST, 16'd1);
    random_phase(200);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: variable_partition_allocator_unit.f
hw/rtl/vpa_pkg.sv
hw/rtl/vpa_ctrl.sv
hw/rtl/vpa_datapath.sv
hw/rtl/variable_partition_allocator_unit.sv
tb/sv/testbench.sv
